// File: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared types and constants for the polytope membership counter.
// ----------------------------------------------------------------------------
package pmc_pkg;

  localparam int MAX_CONSTRAINTS = 64;
  localparam int MAX_DIMS        = 16;

  localparam int ROW_W       = $clog2(MAX_CONSTRAINTS);
  localparam int DIM_W       = $clog2(MAX_DIMS);
  localparam int COEF_ADDR_W = ROW_W + DIM_W;
  localparam int COEF_DEPTH  = MAX_CONSTRAINTS * MAX_DIMS;

  localparam int COEF_W   = 16;
  localparam int BOUND_W  = 40;
  localparam int COORD_W  = 17;
  localparam int TALLY_W  = 32;
  localparam int PROD_W   = COORD_W + 1 + COEF_W;
  localparam int ACC_W    = BOUND_W + 1;

  localparam int ROWS_CFG_W = 7;
  localparam int DIMS_CFG_W = 5;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(65536);

  // input word commands
  localparam logic [1:0] CMD_COEF   = 2'd0;
  localparam logic [1:0] CMD_BOUND  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_USED = 1'd1;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [5:0]                row_index;
    logic [3:0]                dim_index;
    logic signed [COEF_W-1:0]  coef_value;
    logic signed [BOUND_W-1:0] bound_value;
    logic [COORD_W-1:0]        coord_value;
    logic                      last_coord;
  } in_word_t;

  typedef struct packed {
    logic               point_inside;
    logic [TALLY_W-1:0] inside_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic             accept;     // input word taken this cycle
    logic             start;      // evaluation of a point begins
    logic             issue;      // one multiply-accumulate step issued
    logic             first;      // step is the first of its row
    logic             row_end;    // step is the last of its row
    logic [ROW_W-1:0] row;
    logic [DIM_W-1:0] dim;
    logic             zero_dims;  // no dimension used: products are zero
    logic             load_out;   // load result register, update tally
  } pmc_cmd_t;

endpackage

// File: rtl/pmc_ram.sv
// ----------------------------------------------------------------------------
// pmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pmc_datapath.sv
// ----------------------------------------------------------------------------
// pmc_datapath
// Stores, point buffer, multiply-accumulate pipeline, tally and result word.
// ----------------------------------------------------------------------------
module pmc_datapath
  import pmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  item,
  input  pmc_cmd_t  ctrl,
  output out_word_t result
);

  logic coef_we;
  logic bound_we;
  logic sample_we;
  logic clear_we;

  logic [COEF_W-1:0]  coef_rd;
  logic [BOUND_W-1:0] bound_rd;

  logic [COORD_W-1:0] pbuf [MAX_DIMS];
  logic [COORD_W-1:0] coord_sat;

  // stage 1: operands read
  logic               v1, first1, end1;
  logic [COORD_W-1:0] coord1;
  // stage 2: product
  logic                      v2, first2, end2;
  logic signed [PROD_W-1:0]  prod2;
  logic signed [PROD_W-1:0]  prod_full;
  logic [BOUND_W-1:0]        bound2;
  // stage 3: row sum
  logic                      v3, end3;
  logic signed [ACC_W-1:0]   acc3;
  logic [BOUND_W-1:0]        bound3;

  logic               fail;
  logic [TALLY_W-1:0] tally;
  logic [TALLY_W-1:0] tally_next;

  assign coef_we   = ctrl.accept && (item.cmd == CMD_COEF);
  assign bound_we  = ctrl.accept && (item.cmd == CMD_BOUND);
  assign sample_we = ctrl.accept && (item.cmd == CMD_SAMPLE);
  assign clear_we  = ctrl.accept && (item.cmd == CMD_CLEAR);

  pmc_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr ({item.row_index, item.dim_index}),
    .wdata (item.coef_value),
    .raddr ({ctrl.row, ctrl.dim}),
    .rdata (coef_rd)
  );

  pmc_ram #(.WIDTH(BOUND_W), .DEPTH(MAX_CONSTRAINTS)) u_bound_ram (
    .clk   (clk),
    .we    (bound_we),
    .waddr (item.row_index),
    .wdata (item.bound_value),
    .raddr (ctrl.row),
    .rdata (bound_rd)
  );

  assign coord_sat = (item.coord_value > COORD_ONE) ? COORD_ONE : item.coord_value;

  always_ff @(posedge clk) begin
    if (sample_we) begin
      pbuf[item.dim_index] <= coord_sat;
    end
  end

  assign prod_full = $signed({1'b0, coord1}) * $signed(coef_rd);

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctrl.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    first1 <= ctrl.first;
    end1   <= ctrl.row_end;
    coord1 <= pbuf[ctrl.dim];

    first2 <= first1;
    end2   <= end1;
    prod2  <= ctrl.zero_dims ? '0 : prod_full;
    bound2 <= bound_rd;

    end3   <= end2;
    bound3 <= bound2;
    if (v2) begin
      acc3 <= (first2 ? '0 : acc3) + {{(ACC_W-PROD_W){prod2[PROD_W-1]}}, prod2};
    end
  end

  assign tally_next = (!fail && (tally != '1)) ? tally + 1'b1 : tally;

  always_ff @(posedge clk) begin
    if (rst) begin
      fail  <= 1'b0;
      tally <= '0;
    end else begin
      if (ctrl.start) begin
        fail <= 1'b0;
      end else if (v3 && end3 && (acc3 > $signed({bound3[BOUND_W-1], bound3}))) begin
        fail <= 1'b1;
      end
      if (clear_we) begin
        tally <= '0;
      end else if (ctrl.load_out) begin
        tally <= tally_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      result.point_inside <= !fail;
      result.inside_count <= tally_next;
    end
  end

  // tally moves by at most one per cycle unless cleared
  a_tally_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (tally == $past(tally)) || (tally == $past(tally) + 1'b1) || (tally == '0))
    else $error("tally jumped");

  // tally changes only on a result or a clear
  a_tally_cause: assert property (@(posedge clk) disable iff (rst)
    (!ctrl.load_out && !clear_we) |=> (tally == $past(tally)))
    else $error("tally changed without cause");

  // an issued step moves one stage per cycle
  a_pipe_shift: assert property (@(posedge clk) disable iff (rst)
    v1 |=> v2)
    else $error("pipeline step lost");

endmodule

// File: rtl/pmc_ctrl.sv
// ----------------------------------------------------------------------------
// pmc_ctrl
// Sequencer: configuration registers, row/dimension walk, result handshake.
// ----------------------------------------------------------------------------
module pmc_ctrl
  import pmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [1:0]            item_cmd,
  input  logic                  item_last,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output pmc_cmd_t              ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t                state;
  logic [ROW_W-1:0]      row_cnt;
  logic [DIM_W-1:0]      dim_cnt;
  logic [1:0]            drain_cnt;
  logic [ROWS_CFG_W-1:0] rows_used;
  logic [DIMS_CFG_W-1:0] dims_used;

  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [DIMS_CFG_W-1:0] dims_eff;
  logic [ROW_W-1:0]      row_last;
  logic [DIM_W-1:0]      dim_last;
  logic [ROWS_CFG_W-1:0] rows_m1;
  logic [DIMS_CFG_W-1:0] dims_m1;
  logic                  accept;
  logic                  last_sample;
  logic                  load_out;

  assign rows_eff = (rows_used > ROWS_CFG_W'(MAX_CONSTRAINTS)) ?
                    ROWS_CFG_W'(MAX_CONSTRAINTS) : rows_used;
  assign dims_eff = (dims_used > DIMS_CFG_W'(MAX_DIMS)) ? DIMS_CFG_W'(MAX_DIMS) : dims_used;
  assign rows_m1  = rows_eff - 1'b1;
  assign dims_m1  = dims_eff - 1'b1;
  assign row_last = rows_m1[ROW_W-1:0];
  assign dim_last = (dims_eff == '0) ? '0 : dims_m1[DIM_W-1:0];

  assign item_ready  = (state == S_IDLE);
  assign accept      = item_valid && item_ready;
  assign last_sample = accept && (item_cmd == CMD_SAMPLE) && item_last;
  assign load_out    = (state == S_FINISH) && (!result_valid || result_ready);

  always_comb begin
    ctrl           = '0;
    ctrl.accept    = accept;
    ctrl.start     = last_sample;
    ctrl.issue     = (state == S_RUN);
    ctrl.first     = (dim_cnt == '0);
    ctrl.row_end   = (dim_cnt == dim_last);
    ctrl.row       = row_cnt;
    ctrl.dim       = dim_cnt;
    ctrl.zero_dims = (dims_eff == '0);
    ctrl.load_out  = load_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_cnt      <= '0;
      dim_cnt      <= '0;
      drain_cnt    <= '0;
      rows_used    <= ROWS_CFG_W'(1);
      dims_used    <= DIMS_CFG_W'(1);
      result_valid <= 1'b0;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          REG_ROWS_USED: rows_used <= cfg_data[ROWS_CFG_W-1:0];
          REG_DIMS_USED: dims_used <= cfg_data[DIMS_CFG_W-1:0];
          default: ;
        endcase
      end

      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (last_sample) begin
            row_cnt <= '0;
            dim_cnt <= '0;
            state   <= (rows_eff == '0) ? S_FINISH : S_RUN;
          end
        end
        S_RUN: begin
          if (dim_cnt == dim_last) begin
            dim_cnt <= '0;
            if (row_cnt == row_last) begin
              drain_cnt <= '0;
              state     <= S_DRAIN;
            end else begin
              row_cnt <= row_cnt + 1'b1;
            end
          end else begin
            dim_cnt <= dim_cnt + 1'b1;
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRAIN_LAST) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !load_out)
    else $error("result overwritten");

  // walk stays inside the active rows
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ({1'b0, row_cnt} < rows_eff))
    else $error("row counter out of range");

  // a point with active rows starts the walk on the next cycle
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    (last_sample && (rows_eff != '0)) |=> (state == S_RUN) && (row_cnt == '0))
    else $error("evaluation did not start");

endmodule

// File: rtl/polytope_membership_counter_core.sv
// ----------------------------------------------------------------------------
// polytope_membership_counter_core
// Tests sample points against A*x <= b and counts points inside the polytope.
// ----------------------------------------------------------------------------
// Coefficient, bound, clear and non-final coordinate words start no evaluation.
// A final coordinate starts an evaluation: one MAC step per row and dimension
// (one per row at zero dims), then a drain of the MAC pipeline and a result
// load once the output register is free; zero rows go straight to the load.
// Input is held off during the walk and while a finished result waits behind
// an unaccepted one. Sync reset: tally 0, rows 1, dims 1, stores left unwritten.
// ----------------------------------------------------------------------------
module polytope_membership_counter_core
  import pmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  // input words: coefficient/bound loads, coordinates, clear
  input  logic                  item_valid,
  output logic                  item_ready,
  input  in_word_t              item,

  // result words: one per final coordinate
  output logic                  result_valid,
  input  logic                  result_ready,
  output out_word_t             result,

  // configuration: index 0 rows used, index 1 dimensions used
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // command bundle from the sequencer into the datapath
  pmc_cmd_t ctrl;

  // Sequencer: holds the config registers, walks row by row and dimension by
  // dimension, drains the MAC pipeline and handles the result handshake.
  // Input words are taken only while no evaluation runs; a finished result
  // may still be waiting in the output register while new words load.
  pmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_cmd     (item.cmd),
    .item_last    (item.last_coord),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctrl         (ctrl)
  );

  // Datapath: coefficient and bound RAMs, point buffer, 3-stage multiply-
  // accumulate with a bound compare per row, saturating tally, result register.
  pmc_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctrl   (ctrl),
    .result (result)
  );

endmodule

// File: bench/tb_polytope_membership_counter_core.sv
// ----------------------------------------------------------------------------
// tb_polytope_membership_counter_core
// Self-checking bench for the polytope membership counter core.
// ----------------------------------------------------------------------------
// Loads constraint rows and bounds, streams sample points one coordinate per
// word, and checks every verdict and running count against an in-bench
// predictor of A*x <= b. A short directed part hits the arithmetic edges
// (dot product equal to the bound, saturated coordinates, extreme
// coefficients and bounds, clear, stray last marks). After that, phases run
// under several row and dimension settings, among them zero rows, zero
// dimensions, settings past the maximum, and the full size. The sender runs
// in random bursts. The receiver stalls in modes of its own.
// ----------------------------------------------------------------------------
module tb_polytope_membership_counter_core;
  import pmc_pkg::*;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  item_valid   = 1'b0;
  logic                  item_ready;
  in_word_t              item         = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  out_word_t             result;
  logic                  cfg_en       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  polytope_membership_counter_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  in_word_t  pending_words[$];      // words waiting for the driver
  out_word_t expected_verdicts[$];  // predicted result words, oldest first
  bit        mismatch_seen = 1'b0;
  logic      word_taken    = 1'b0;  // input handshake completed at last posedge
  longint    cycle_count   = 0;
  longint    cycle_budget  = 20000; // grows with every queued word and pause

  // Generator view: which store entries hold data. Together they keep
  // evaluations off entries that were never written.
  bit coef_seen  [COEF_DEPTH];
  bit bound_seen [MAX_CONSTRAINTS];
  bit coord_seen [MAX_DIMS];
  int gen_rows = 1;                 // effective rows and dims in force
  int gen_dims = 1;
  int words_queued = 0;

  // --------------------------------------------------------------------------
  // Predictor: its own copy of the stores, tally and settings
  // --------------------------------------------------------------------------
  logic signed [COEF_W-1:0]  coef_mem  [COEF_DEPTH];
  logic signed [BOUND_W-1:0] bound_mem [MAX_CONSTRAINTS];
  logic [COORD_W-1:0]        coord_mem [MAX_DIMS];
  logic [TALLY_W-1:0]        tally;
  logic [ROWS_CFG_W-1:0]     rows_setting;
  logic [DIMS_CFG_W-1:0]     dims_setting;

  // True when every active row's exact dot product stays at or below its
  // bound. Zero rows is trivially inside; zero dims gives all-zero sums.
  function automatic logic dot_products_hold();
    int     nr, nd;
    longint acc;
    nr = (rows_setting > MAX_CONSTRAINTS) ? MAX_CONSTRAINTS : int'(rows_setting);
    nd = (dims_setting > MAX_DIMS) ? MAX_DIMS : int'(dims_setting);
    for (int r = 0; r < nr; r++) begin
      acc = 0;
      for (int d = 0; d < nd; d++)
        acc += longint'(coord_mem[d]) * longint'(coef_mem[r * MAX_DIMS + d]);
      if (acc > longint'(bound_mem[r]))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one accepted input word; a final coordinate queues a verdict.
  task automatic absorb_word(in_word_t w);
    logic      holds;
    out_word_t verdict;
    case (w.cmd)
      CMD_COEF:  coef_mem[{w.row_index, w.dim_index}] = w.coef_value;
      CMD_BOUND: bound_mem[w.row_index] = w.bound_value;
      CMD_CLEAR: tally = '0;
      CMD_SAMPLE: begin
        // coordinates above one clamp to exactly one
        coord_mem[w.dim_index] = (w.coord_value > COORD_ONE) ? COORD_ONE : w.coord_value;
        if (w.last_coord) begin
          holds = dot_products_hold();
          if (holds && tally != '1)
            tally = tally + 1'b1;
          verdict.point_inside = holds;
          verdict.inside_count = tally;
          expected_verdicts.push_back(verdict);
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Monitor: register writes, accepted words and result words, all sampled
  // at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      tally        = '0;
      rows_setting = ROWS_CFG_W'(1);
      dims_setting = DIMS_CFG_W'(1);
      expected_verdicts.delete();
      word_taken  <= 1'b0;
    end else begin
      if (cfg_en) begin
        if (cfg_index == REG_ROWS_USED)
          rows_setting = cfg_data[ROWS_CFG_W-1:0];
        else if (cfg_index == REG_DIMS_USED)
          dims_setting = cfg_data[DIMS_CFG_W-1:0];
      end
      word_taken <= item_valid && item_ready;
      if (item_valid && item_ready)
        absorb_word(item);
      if (result_valid && result_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result word with no verdict pending: inside=%0d count=%0d",
                 result.point_inside, result.inside_count);
          mismatch_seen = 1'b1;
        end else begin
          want = expected_verdicts.pop_front();
          if (result.point_inside !== want.point_inside) begin
            $error("point_inside: expected %0d, actual %0d",
                   want.point_inside, result.point_inside);
            mismatch_seen = 1'b1;
          end
          if (result.inside_count !== want.inside_count) begin
            $error("inside_count: expected %0d, actual %0d",
                   want.inside_count, result.inside_count);
            mismatch_seen = 1'b1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of words with random gaps; a word holds until taken
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || word_taken) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        item_valid <= 1'b0;
        if (gap_left > 0)
          gap_left <= gap_left - 1;
      end else begin
        item       <= pending_words.pop_front();
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          // a quarter of bursts run straight into the next one
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switches between always ready, coin flip and heavy stall
  // --------------------------------------------------------------------------
  int ready_mode = 0;
  int ready_run  = 0;

  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_run  <= $urandom_range(10, 80);
      end else begin
        ready_run <= ready_run - 1;
      end
      case (ready_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= 1'($urandom);
        default: result_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 4 * cycle_budget) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_word_t word_of(logic [1:0] cmd, int row, int dim,
                                       logic signed [COEF_W-1:0] coef,
                                       logic signed [BOUND_W-1:0] bound,
                                       logic [COORD_W-1:0] coord, logic last);
    in_word_t w;
    w.cmd         = cmd;
    w.row_index   = 6'(row);
    w.dim_index   = 4'(dim);
    w.coef_value  = coef;
    w.bound_value = bound;
    w.coord_value = coord;
    w.last_coord  = last;
    return w;
  endfunction

  // mostly small coefficients so that verdicts split between in and out
  function automatic logic signed [COEF_W-1:0] rand_coef();
    if ($urandom_range(0, 9) < 7)
      return COEF_W'(int'($urandom_range(0, 8192)) - 4096);
    return COEF_W'($urandom);
  endfunction

  function automatic logic signed [BOUND_W-1:0] rand_bound();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return {1'b0, {(BOUND_W-1){1'b1}}};
    if (pick == 1) return {1'b1, {(BOUND_W-1){1'b0}}};
    if (pick == 2) return '0;
    if (pick == 3) return '1;
    if (pick < 15) return BOUND_W'(longint'($urandom) - 64'sh8000_0000);
    return {8'($urandom), 32'($urandom)};
  endfunction

  // zero, exactly one, above one (clamps), or anywhere in [0,1]
  function automatic logic [COORD_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return COORD_ONE;
    if (pick == 2) return COORD_W'($urandom_range(65537, 131071));
    return COORD_W'($urandom_range(0, 65536));
  endfunction

  function automatic int pick_row();
    if ($urandom_range(0, 3) != 0)
      return $urandom_range(0, (gen_rows == 0) ? 0 : gen_rows - 1);
    return $urandom_range(0, MAX_CONSTRAINTS - 1);
  endfunction

  function automatic int pick_dim();
    if ($urandom_range(0, 3) != 0)
      return $urandom_range(0, (gen_dims == 0) ? 0 : gen_dims - 1);
    return $urandom_range(0, MAX_DIMS - 1);
  endfunction

  task automatic queue_word(in_word_t w);
    pending_words.push_back(w);
    words_queued++;
    cycle_budget += 60;
    case (w.cmd)
      CMD_COEF:  coef_seen[{w.row_index, w.dim_index}] = 1'b1;
      CMD_BOUND: bound_seen[w.row_index] = 1'b1;
      CMD_SAMPLE: begin
        coord_seen[w.dim_index] = 1'b1;
        if (w.last_coord)
          cycle_budget += gen_rows * gen_dims + 10;
      end
      default: ;
    endcase
  endtask

  // Writes any entry the next evaluation could touch that has no data yet.
  // Row 0 and dim 0 are covered even at zero rows or zero dims.
  task automatic ensure_loaded();
    int nr, nd;
    nr = (gen_rows == 0) ? 1 : gen_rows;
    nd = (gen_dims == 0) ? 1 : gen_dims;
    for (int r = 0; r < nr; r++) begin
      if (!bound_seen[r])
        queue_word(word_of(CMD_BOUND, r, $urandom_range(0, 15), rand_coef(),
                           rand_bound(), rand_coord(), 1'($urandom)));
      for (int d = 0; d < nd; d++)
        if (!coef_seen[r * MAX_DIMS + d])
          queue_word(word_of(CMD_COEF, r, d, rand_coef(), rand_bound(),
                             rand_coord(), 1'($urandom)));
    end
    for (int d = 0; d < nd; d++)
      if (!coord_seen[d])
        queue_word(word_of(CMD_SAMPLE, $urandom_range(0, 63), d, rand_coef(),
                           rand_bound(), rand_coord(), 1'b0));
  endtask

  // One sample point: the used coordinates in shuffled order, last one marked.
  // Now and then only part of the point is rewritten, so old coordinates
  // carry over from the previous point.
  task automatic queue_point();
    int order[MAX_DIMS];
    int n, k, j, tmp;
    ensure_loaded();
    n = gen_dims;
    if (n == 0) begin
      queue_word(word_of(CMD_SAMPLE, $urandom_range(0, 63), $urandom_range(0, 15),
                         rand_coef(), rand_bound(), rand_coord(), 1'b1));
      return;
    end
    for (int i = 0; i < n; i++)
      order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    k = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n;
    for (int i = 0; i < k; i++)
      queue_word(word_of(CMD_SAMPLE, $urandom_range(0, 63), order[i], rand_coef(),
                         rand_bound(), rand_coord(), i == k - 1));
  endtask

  // Holds off until the driver is empty and every verdict has come back,
  // then lets a full evaluation's worth of cycles pass.
  task automatic settle();
    int linger;
    linger = gen_rows * gen_dims + 20;
    cycle_budget += linger + 200;
    while (pending_words.size() != 0 || item_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (linger) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_en    <= 1'b0;
  endtask

  // One setting of both registers, then a random mix: mostly points, plus
  // coefficient and bound rewrites, clears and fully random words.
  task automatic run_phase(int rows_cfg, int dims_cfg, int n_words);
    int       stop, pick;
    in_word_t w;
    settle();
    write_reg(REG_ROWS_USED, CFG_DATA_W'(rows_cfg));
    // bits above the 5-bit dims field are don't-care; toggle them anyway
    write_reg(REG_DIMS_USED, {2'($urandom), 5'(dims_cfg)});
    gen_rows = (rows_cfg > MAX_CONSTRAINTS) ? MAX_CONSTRAINTS : rows_cfg;
    gen_dims = (dims_cfg > MAX_DIMS) ? MAX_DIMS : dims_cfg;
    ensure_loaded();
    stop = words_queued + n_words;
    while (words_queued < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_point();
      end else if (pick < 75) begin
        queue_word(word_of(CMD_COEF, pick_row(), pick_dim(), rand_coef(),
                           rand_bound(), rand_coord(), 1'($urandom)));
      end else if (pick < 85) begin
        queue_word(word_of(CMD_BOUND, pick_row(), $urandom_range(0, 15), rand_coef(),
                           rand_bound(), rand_coord(), 1'($urandom)));
      end else if (pick < 89) begin
        queue_word(word_of(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 15),
                           rand_coef(), rand_bound(), rand_coord(), 1'($urandom)));
      end else begin
        w = word_of(2'($urandom), $urandom_range(0, 63), $urandom_range(0, 15),
                    COEF_W'($urandom), {8'($urandom), 32'($urandom)},
                    COORD_W'($urandom), 1'($urandom));
        if (w.cmd == CMD_SAMPLE && w.last_coord)
          ensure_loaded();
        queue_word(w);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, at reset settings (one row, one dimension).
    // largest coefficient, largest bound: inside
    queue_word(word_of(CMD_COEF, 0, 0, 16'sh7fff, '0, '0, 1'b0));
    queue_word(word_of(CMD_BOUND, 0, 0, '0, 40'sh7f_ffff_ffff, '0, 1'b0));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, COORD_ONE, 1'b1));
    // dot product equal to bound holds, one below fails (coordinate clamps)
    queue_word(word_of(CMD_BOUND, 0, 0, '0, 40'sd2147418112, '0, 1'b0));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, COORD_ONE, 1'b1));
    queue_word(word_of(CMD_BOUND, 0, 0, '0, 40'sd2147418111, '0, 1'b0));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, 17'h1ffff, 1'b1));
    // most negative coefficient and bound; stray last marks on writes
    queue_word(word_of(CMD_COEF, 0, 0, 16'sh8000, '0, '0, 1'b1));
    queue_word(word_of(CMD_BOUND, 0, 0, '0, 40'sh80_0000_0000, '0, 1'b1));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, '0, 1'b1));
    queue_word(word_of(CMD_BOUND, 0, 0, '0, '0, '0, 1'b0));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, '0, 1'b1));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, 17'd1, 1'b1));
    // clear with a last mark gives no result; unmarked coordinate neither
    queue_word(word_of(CMD_CLEAR, 0, 0, '0, '0, '0, 1'b1));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, COORD_ONE, 1'b0));
    queue_word(word_of(CMD_CLEAR, 63, 15, 16'shffff, '1, '1, 1'b0));
    // top row and dimension, outside the active set
    queue_word(word_of(CMD_COEF, 63, 15, 16'sh7fff, '0, '0, 1'b0));
    queue_word(word_of(CMD_BOUND, 63, 15, '0, 40'sh7f_ffff_ffff, '0, 1'b0));
    queue_word(word_of(CMD_SAMPLE, 0, 15, '0, '0, 17'd12345, 1'b0));
    queue_word(word_of(CMD_SAMPLE, 0, 0, '0, '0, 17'd65535, 1'b1));

    // the full-size load alone is about 1100 words
    run_phase(0, 5, 20);        // zero rows: always inside
    run_phase(3, 0, 20);        // zero dims: sums are zero
    run_phase(127, 31, 40);     // both past their maximum, clamp to full size
    repeat (4)
      run_phase($urandom_range(1, 8), $urandom_range(1, 6), 25);
    run_phase(MAX_CONSTRAINTS, MAX_DIMS, 20);
    run_phase(1, 1, 20);
    settle();

    if (!mismatch_seen)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/pmc_pkg.sv
rtl/pmc_ram.sv
rtl/pmc_datapath.sv
rtl/pmc_ctrl.sv
rtl/polytope_membership_counter_core.sv
bench/tb_polytope_membership_counter_core.sv
